// File: rtl/tfp_pkg.sv
// Shared constants and types for the telemetry frame parser.
package tfp_pkg;

  // Frame framing bytes and checks
  localparam logic [7:0] START_BYTE  = 8'd2;
  localparam logic [7:0] END_BYTE    = 8'd3;
  localparam logic [7:0] CMD_VALUES  = 8'd4;
  localparam logic [6:0] MIN_LENGTH  = 7'd29;
  localparam logic [7:0] MAX_PAYLOAD = 8'd80;

  // CRC-16 XMODEM
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Payload positions of the captured fields
  localparam logic [6:0] POS_CMD       = 7'd0;
  localparam logic [6:0] POS_CUR_FIRST = 7'd9;
  localparam logic [6:0] POS_CUR_LAST  = 7'd12;
  localparam logic [6:0] POS_DUTY_FIRST = 7'd21;
  localparam logic [6:0] POS_DUTY_LAST  = 7'd22;
  localparam logic [6:0] POS_RPM_FIRST = 7'd23;
  localparam logic [6:0] POS_RPM_LAST  = 7'd26;
  localparam logic [6:0] POS_VOLT_FIRST = 7'd27;
  localparam logic [6:0] POS_VOLT_LAST  = 7'd28;

  typedef struct packed {
    logic signed [31:0] input_current_centiamps;
    logic signed [15:0] duty_permille;
    logic signed [31:0] electrical_rpm;
    logic signed [15:0] input_voltage_decivolts;
  } telem_t;

  typedef struct packed {
    logic   hit;      // frame passed all checks on this beat
    logic   at_end;   // parser waits for the end byte
    telem_t data;
  } parse_result_t;

endpackage

// File: rtl/tfp_if.sv
// Valid/ready channel interfaces for the received bytes and telemetry results.
interface tfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfp_telem_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] input_current_centiamps;
  logic signed [15:0] duty_permille;
  logic signed [31:0] electrical_rpm;
  logic signed [15:0] input_voltage_decivolts;

  modport source (output valid, output input_current_centiamps, output duty_permille,
                  output electrical_rpm, output input_voltage_decivolts, input ready);
  modport sink   (input valid, input input_current_centiamps, input duty_permille,
                  input electrical_rpm, input input_voltage_decivolts, output ready);
endinterface

// File: rtl/tfp_crc16_step.sv
// CRC-16 (poly 0x1021, MSB first) update over one byte.
module tfp_crc16_step (
  input  logic [15:0] crc,
  input  logic [7:0]  data,
  output logic [15:0] crc_next
);
  import tfp_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_next = c;
  end

endmodule

// File: rtl/tfp_parser.sv
// Frame phase machine, running CRC, field capture and end-of-frame check.
module tfp_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             rx_byte,
  output tfp_pkg::parse_result_t res
);
  import tfp_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEN    = 6'b000010,
    PH_DATA   = 6'b000100,
    PH_CRC_HI = 6'b001000,
    PH_CRC_LO = 6'b010000,
    PH_END    = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  logic [6:0]  frame_length, frame_length_next;
  logic [6:0]  byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;
  logic [7:0]  command_code, command_code_next;
  logic [31:0] current_capture, current_capture_next;
  logic [15:0] duty_capture, duty_capture_next;
  logic [31:0] rpm_capture, rpm_capture_next;
  logic [15:0] voltage_capture, voltage_capture_next;
  logic [15:0] crc_step;
  logic [6:0]  count_inc;
  logic        hit;

  tfp_crc16_step u_crc (
    .crc      (running_crc),
    .data     (rx_byte),
    .crc_next (crc_step)
  );

  assign count_inc = byte_count + 7'd1;

  always_comb begin
    phase_next           = phase;
    frame_length_next    = frame_length;
    byte_count_next      = byte_count;
    running_crc_next     = running_crc;
    received_crc_next    = received_crc;
    command_code_next    = command_code;
    current_capture_next = current_capture;
    duty_capture_next    = duty_capture;
    rpm_capture_next     = rpm_capture;
    voltage_capture_next = voltage_capture;
    hit                  = 1'b0;

    if (take) begin
      unique case (phase)
        PH_IDLE: begin
          if (rx_byte == START_BYTE) phase_next = PH_LEN;
        end
        PH_LEN: begin
          byte_count_next   = '0;
          running_crc_next  = '0;
          frame_length_next = rx_byte[6:0];
          // length 0 or above the maximum drops the frame
          if (rx_byte != 8'd0 && rx_byte <= MAX_PAYLOAD) begin
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_IDLE;
          end
        end
        PH_DATA: begin
          priority if (byte_count == POS_CMD) begin
            command_code_next = rx_byte;
          end else if (byte_count >= POS_CUR_FIRST && byte_count <= POS_CUR_LAST) begin
            current_capture_next = {current_capture[23:0], rx_byte};
          end else if (byte_count >= POS_DUTY_FIRST && byte_count <= POS_DUTY_LAST) begin
            duty_capture_next = {duty_capture[7:0], rx_byte};
          end else if (byte_count >= POS_RPM_FIRST && byte_count <= POS_RPM_LAST) begin
            rpm_capture_next = {rpm_capture[23:0], rx_byte};
          end else if (byte_count >= POS_VOLT_FIRST && byte_count <= POS_VOLT_LAST) begin
            voltage_capture_next = {voltage_capture[7:0], rx_byte};
          end else begin
            command_code_next = command_code;
          end
          running_crc_next = crc_step;
          byte_count_next  = count_inc;
          if (count_inc == frame_length) phase_next = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          received_crc_next = {rx_byte, 8'h00};
          phase_next        = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          received_crc_next = {received_crc[15:8], rx_byte};
          phase_next        = PH_END;
        end
        PH_END: begin
          hit = (rx_byte == END_BYTE) && (received_crc == running_crc) &&
                (frame_length >= MIN_LENGTH) && (command_code == CMD_VALUES);
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      frame_length <= '0;
      byte_count   <= '0;
      running_crc  <= '0;
      received_crc <= '0;
      command_code <= '0;
    end else begin
      phase        <= phase_next;
      frame_length <= frame_length_next;
      byte_count   <= byte_count_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
      command_code <= command_code_next;
    end
  end

  always_ff @(posedge clk) begin
    current_capture <= current_capture_next;
    duty_capture    <= duty_capture_next;
    rpm_capture     <= rpm_capture_next;
    voltage_capture <= voltage_capture_next;
  end

  assign res.hit    = hit;
  assign res.at_end = (phase == PH_END);
  assign res.data.input_current_centiamps = $signed(current_capture);
  assign res.data.duty_permille           = $signed(duty_capture);
  assign res.data.electrical_rpm          = $signed(rpm_capture);
  assign res.data.input_voltage_decivolts = $signed(voltage_capture);

  // payload phase must leave for the CRC bytes once the count reaches the length
  a_len_exit: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_DATA && count_inc == frame_length) |=> (phase == PH_CRC_HI))
    else $error("payload phase did not end at frame length");

  // a frame in progress never counts past its length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (byte_count < frame_length))
    else $error("byte count ran past frame length");

  // a hit only ever comes from the end-byte phase
  a_hit_phase: assert property (@(posedge clk) disable iff (rst)
    hit |-> (phase == PH_END))
    else $error("result raised outside end-byte phase");

endmodule

// File: rtl/telemetry_frame_parser_crc16.sv
// Top level: serial-byte frame parser with CRC-16 check and telemetry result register.
// Latency: a result beat is valid the cycle after its end byte is taken.
// Throughput: one byte per cycle; input stalls only on the end byte while a
//   previous result still waits in the output register.
// Reset (rst, synchronous): parser to idle, CRC and counters cleared, result
//   register emptied. Captured field values are not cleared.
module telemetry_frame_parser_crc16 (
  input logic        clk,
  input logic        rst,
  tfp_byte_if.sink   rx,
  tfp_telem_if.source tlm
);
  import tfp_pkg::*;

  parse_result_t res;
  logic          take;
  logic          out_valid, out_valid_next;
  telem_t        out_data;

  // Only the end byte can produce a result, so the output register only
  // back-pressures the input in that one phase.
  assign rx.ready = !res.at_end || !out_valid || tlm.ready;
  assign take     = rx.valid && rx.ready;

  tfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .res     (res)
  );

  // Result register: loads on a hit, drains on an accepted beat.
  always_comb begin
    out_valid_next = out_valid;
    if (res.hit) begin
      out_valid_next = 1'b1;
    end else if (tlm.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res.hit) begin
      out_data <= res.data;
    end
  end

  assign tlm.valid                   = out_valid;
  assign tlm.input_current_centiamps = out_data.input_current_centiamps;
  assign tlm.duty_permille           = out_data.duty_permille;
  assign tlm.electrical_rpm          = out_data.electrical_rpm;
  assign tlm.input_voltage_decivolts = out_data.input_voltage_decivolts;

  // a result is only raised by an accepted byte
  a_hit_taken: assert property (@(posedge clk) disable iff (rst)
    res.hit |-> take)
    else $error("result without accepted byte");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !tlm.ready) |-> !res.hit)
    else $error("pending result overwritten");

  // every hit shows up on the output next cycle
  a_hit_out: assert property (@(posedge clk) disable iff (rst)
    res.hit |=> tlm.valid)
    else $error("hit did not reach output register");

endmodule
